[design/dra_pkg.sv]
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and constants for the DNS reply address extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dra_pkg;

    localparam int QUEUE_DEPTH  = 4;
    localparam int HEADER_LEN   = 12;
    localparam int QTAIL_LEN    = 4;
    localparam int FIXED_LEN    = 10;
    localparam int ADDR_LEN     = 4;
    localparam logic [7:0] RCODE_MASK   = 8'h0f;
    localparam logic [7:0] POINTER_BITS = 8'hc0;

    // One payload byte with its classification, as queued between front and back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       is_ptr;
    } t_byte_item;

endpackage

`default_nettype wire

[design/dra_front.sv]
// ----------------------------------------------------------------------------
// dra_front
// Input side: takes payload bytes and classifies them for the name parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dra_front (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_payload_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_full,
    output logic                   o_push,
    output dra_pkg::t_byte_item    o_item
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.data    = i_payload_byte;
        o_item.last    = i_last_byte;
        o_item.is_zero = (i_payload_byte == 8'h00);
        // A length byte with either top bit set is a compression pointer.
        o_item.is_ptr  = ((i_payload_byte & dra_pkg::POINTER_BITS) != 8'h00);
    end

endmodule

`default_nettype wire

[design/dra_queue.sv]
// ----------------------------------------------------------------------------
// dra_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dra_queue #(
    parameter int DEPTH = dra_pkg::QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire dra_pkg::t_byte_item i_item,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output dra_pkg::t_byte_item      o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dra_pkg::t_byte_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[design/dra_parser.sv]
// ----------------------------------------------------------------------------
// dra_parser
// Back side: walks header, question and answer records one byte per cycle and
// holds each result in an output register; a last byte waits until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dra_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_item_valid,
    input  wire dra_pkg::t_byte_item i_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [1:0]               o_status,
    output logic [31:0]              o_resolved_address,
    output logic [3:0]               o_response_code,
    output logic [15:0]              o_answer_total
);

    localparam logic [3:0] PH_HEADER    = 4'd0;
    localparam logic [3:0] PH_QNAME     = 4'd1;
    localparam logic [3:0] PH_QNAME_PTR = 4'd2;
    localparam logic [3:0] PH_QTAIL     = 4'd3;
    localparam logic [3:0] PH_ANAME     = 4'd4;
    localparam logic [3:0] PH_ANAME_PTR = 4'd5;
    localparam logic [3:0] PH_AFIXED    = 4'd6;
    localparam logic [3:0] PH_ADATA     = 4'd7;
    localparam logic [3:0] PH_DONE      = 4'd8;

    localparam logic [1:0] ST_RESOLVED  = 2'd0;
    localparam logic [1:0] ST_NO_ANSWER = 2'd1;
    localparam logic [1:0] ST_SERVER    = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_ans_left, n_ans_left;
    logic [15:0] r_ancount, n_ancount;
    logic [3:0]  r_rcode, n_rcode;
    logic [7:0]  r_label, n_label;
    logic        r_type_ok, n_type_ok;
    logic        r_class_ok, n_class_ok;
    logic [15:0] r_data, n_data;
    logic        r_take, n_take;
    logic [31:0] r_addr, n_addr;
    logic        r_found, n_found;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_addr;
    logic [3:0]  r_out_rcode;
    logic [15:0] r_out_ancount;
    logic [1:0]  n_status;

    logic [7:0]  b;
    logic [15:0] ans_dec;
    logic [15:0] len_full;
    logic [15:0] data_dec;
    logic        finish;

    assign b        = i_item.data;
    assign ans_dec  = r_ans_left - 16'd1;
    assign len_full = {r_data[7:0], b};
    assign data_dec = r_data - 16'd1;

    // A last byte may only be taken when the output register can take its result.
    assign o_pop  = i_item_valid && (!i_item.last || !r_out_valid || i_ready);
    assign finish = o_pop && i_item.last;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_ans_left = r_ans_left;
        n_ancount  = r_ancount;
        n_rcode    = r_rcode;
        n_label    = r_label;
        n_type_ok  = r_type_ok;
        n_class_ok = r_class_ok;
        n_data     = r_data;
        n_take     = r_take;
        n_addr     = r_addr;
        n_found    = r_found;
        n_status   = ST_NO_ANSWER;

        if (o_pop) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == 4'd3) begin
                        n_rcode = 4'(b & dra_pkg::RCODE_MASK);
                    end else if (r_pos == 4'd6) begin
                        n_ancount = {b, 8'h00};
                    end else if (r_pos == 4'd7) begin
                        n_ancount = {r_ancount[15:8], b};
                    end
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'(dra_pkg::HEADER_LEN - 1)) begin
                        n_pos      = '0;
                        n_ans_left = n_ancount;
                        n_label    = '0;
                        n_phase    = (n_rcode != 4'd0) ? PH_DONE : PH_QNAME;
                    end
                end
                PH_QNAME, PH_ANAME: begin
                    if (r_label != 8'd0) begin
                        n_label = r_label - 8'd1;
                    end else if (i_item.is_zero) begin
                        // Name ends; the question goes to its tail, an answer to
                        // its fixed fields.
                        n_pos      = '0;
                        n_phase    = (r_phase == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
                        n_type_ok  = 1'b0;
                        n_class_ok = 1'b0;
                        n_data     = '0;
                    end else if (i_item.is_ptr) begin
                        n_phase = (r_phase == PH_QNAME) ? PH_QNAME_PTR : PH_ANAME_PTR;
                    end else begin
                        n_label = b;
                    end
                end
                PH_QNAME_PTR: begin
                    n_phase = PH_QTAIL;
                    n_pos   = '0;
                end
                PH_QTAIL: begin
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'(dra_pkg::QTAIL_LEN - 1)) begin
                        n_pos   = '0;
                        n_label = '0;
                        n_phase = (r_ans_left == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
                PH_ANAME_PTR: begin
                    n_phase    = PH_AFIXED;
                    n_pos      = '0;
                    n_type_ok  = 1'b0;
                    n_class_ok = 1'b0;
                    n_data     = '0;
                end
                PH_AFIXED: begin
                    if (r_pos == 4'd0) begin
                        n_type_ok = (b == 8'd0);
                    end else if (r_pos == 4'd1) begin
                        n_type_ok = r_type_ok && (b == 8'd1);
                    end else if (r_pos == 4'd2) begin
                        n_class_ok = (b == 8'd0);
                    end else if (r_pos == 4'd3) begin
                        n_class_ok = r_class_ok && (b == 8'd1);
                    end else if (r_pos >= 4'd8) begin
                        n_data = len_full;
                    end
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'(dra_pkg::FIXED_LEN - 1)) begin
                        n_pos = '0;
                        if (len_full == 16'd0) begin
                            n_ans_left = ans_dec;
                            n_label    = '0;
                            n_phase    = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                        end else begin
                            n_phase = PH_ADATA;
                            // Only the first class IN, type A record of length four
                            // supplies the address.
                            n_take  = r_type_ok && r_class_ok && !r_found &&
                                      (len_full == 16'(dra_pkg::ADDR_LEN));
                        end
                    end
                end
                PH_ADATA: begin
                    if (r_take) begin
                        n_addr = {r_addr[23:0], b};
                    end
                    n_data = data_dec;
                    if (data_dec == 16'd0) begin
                        if (r_take) begin
                            n_found = 1'b1;
                        end
                        n_pos      = '0;
                        n_ans_left = ans_dec;
                        n_label    = '0;
                        n_phase    = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (n_phase == PH_HEADER) begin
            n_status = ST_TRUNCATED;
        end else if (n_rcode != 4'd0) begin
            n_status = ST_SERVER;
        end else if (n_found) begin
            n_status = ST_RESOLVED;
        end else if (n_phase != PH_DONE) begin
            n_status = ST_TRUNCATED;
        end else begin
            n_status = ST_NO_ANSWER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_phase    <= PH_HEADER;
            r_pos      <= '0;
            r_ans_left <= '0;
            r_ancount  <= '0;
            r_rcode    <= '0;
            r_label    <= '0;
            r_type_ok  <= 1'b0;
            r_class_ok <= 1'b0;
            r_data     <= '0;
            r_take     <= 1'b0;
            r_addr     <= '0;
            r_found    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_ans_left <= n_ans_left;
            r_ancount  <= n_ancount;
            r_rcode    <= n_rcode;
            r_label    <= n_label;
            r_type_ok  <= n_type_ok;
            r_class_ok <= n_class_ok;
            r_data     <= n_data;
            r_take     <= n_take;
            r_addr     <= n_addr;
            r_found    <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_status  <= n_status;
            r_out_addr    <= (n_status == ST_RESOLVED) ? n_addr : 32'd0;
            r_out_rcode   <= n_rcode;
            r_out_ancount <= n_ancount;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_resolved_address = r_out_addr;
    assign o_response_code    = r_out_rcode;
    assign o_answer_total     = r_out_ancount;

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_phase == PH_HEADER) && (r_pos == 4'd0) && !r_found)
        else $error("parser did not restart after the last byte");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("result missing after the last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !finish)
        else $error("pending result overwritten");

    a_addr_only_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_RESOLVED)) |-> (r_out_addr == 32'd0))
        else $error("address shown without resolution");

endmodule

`default_nettype wire

[design/dns_reply_address_extractor_unit.sv]
// ----------------------------------------------------------------------------
// dns_reply_address_extractor_unit
// Parses a DNS reply byte stream and reports the first IPv4 A record address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one payload byte per item, with
//   i_last_byte marking the final byte of the datagram. Output channel
//   (o_valid / i_ready) carries one result per datagram: status, address,
//   RCODE and ANCOUNT.
//   Throughput is one byte per cycle while the queue is not full. Each byte
//   is written into a short queue and the parser consumes one queued byte
//   per cycle, except a last byte waiting on a pending result; every byte
//   only steps the parser's phase and field counters. The parser loads the
//   result of a last byte into the output register when it takes that byte.
//   When the receiver stalls, the result waits in the output register while
//   the parser keeps consuming the next datagram; only a second last byte
//   waits, and then the queue fills and o_ready drops.
//   Reset (synchronous, active low) empties the queue, drops o_valid and puts
//   the parser at the start of a header. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_reply_address_extractor_unit #(
    parameter int QUEUE_DEPTH = dra_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_resolved_address,
    output logic [3:0]       o_response_code,
    output logic [15:0]      o_answer_total
);

    dra_pkg::t_byte_item push_item;
    dra_pkg::t_byte_item head_item;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    dra_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .i_full         (full),
        .o_push         (push),
        .o_item         (push_item)
    );

    dra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    dra_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (head_valid),
        .i_item             (head_item),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_resolved_address (o_resolved_address),
        .o_response_code    (o_response_code),
        .o_answer_total     (o_answer_total)
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// DNS reply address extractor testbench
// Feeds DNS reply datagrams one byte per item. It starts with a short table of
// header cases, then sends random well-formed replies, cut-off replies and
// noise. Typed rows are checked by the table; the rest by an in-bench parser.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [3:0] {
        P_HEADER, P_QNAME, P_QNAME_PTR, P_QTAIL, P_ANAME, P_ANAME_PTR,
        P_AFIXED, P_ADATA, P_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_RESOLVED, ST_NO_ANSWER, ST_SERVER_ERR, ST_TRUNCATED
    } t_status;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic [3:0]  rcode;
        logic [15:0] ancount;
    } t_reply;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_reply     want;
    } t_row;

    localparam int DIR_ROWS     = 26;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PERCENT = 17;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_payload_byte = 8'h00;
    logic        i_last_byte    = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_resolved_address;
    logic [3:0]  o_response_code;
    logic [15:0] o_answer_total;

    dns_reply_address_extractor_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_payload_byte     (i_payload_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_resolved_address (o_resolved_address),
        .o_response_code    (o_response_code),
        .o_answer_total     (o_answer_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Header cases: two single bytes, a full header with a server error and the
    // widest answer count, and two headers cut short.
    t_row dir_rows [DIR_ROWS] = '{
        '{8'hff, 1'b1, 1'b1, '{ST_TRUNCATED, 32'h0, 4'h0, 16'h0000}},
        '{8'h00, 1'b1, 1'b1, '{ST_TRUNCATED, 32'h0, 4'h0, 16'h0000}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{ST_SERVER_ERR, 32'h0, 4'hf, 16'hffff}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{ST_TRUNCATED, 32'h0, 4'h5, 16'h0000}},
        '{8'hab, 1'b0, 1'b0, '0},
        '{8'hcd, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h12, 1'b1, 1'b0, '0}
    };

    // Parser state of the byte stream as the block should see it.
    t_phase      ph;
    logic [15:0] pos;
    logic [15:0] ans_left;
    logic [15:0] an_count;
    logic [3:0]  rcode;
    logic [7:0]  lbl_left;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] dlen;
    logic [31:0] addr_acc;
    logic        addr_hit;

    t_reply     expected_replies [$];
    logic [7:0] dgram [$];
    int         errors       = 0;
    int         sent_items   = 0;
    int         holds_asked  = 0;
    int         holds_served = 0;
    int         hold_left    = 0;
    bit         calm         = 1'b0;

    function void clear_parser();
        ph       = P_HEADER;
        pos      = '0;
        ans_left = '0;
        an_count = '0;
        rcode    = '0;
        lbl_left = '0;
        rtype    = '0;
        rclass   = '0;
        dlen     = '0;
        addr_acc = '0;
        addr_hit = 1'b0;
    endfunction

    // Returns 1 when the name has ended on this byte.
    function automatic logic name_step(input logic [7:0] b, input t_phase ptr_ph);
        if (lbl_left != 0) begin
            lbl_left = lbl_left - 1'b1;
            return 1'b0;
        end
        if (b == 8'h00)
            return 1'b1;
        if ((b & dra_pkg::POINTER_BITS) != 8'h00) begin
            ph = ptr_ph;
            return 1'b0;
        end
        lbl_left = b;
        return 1'b0;
    endfunction

    function void next_answer();
        lbl_left = '0;
        ph = (ans_left == 0) ? P_DONE : P_ANAME;
    endfunction

    function void finish_record();
        ans_left = ans_left - 1'b1;
        next_answer();
    endfunction

    function void open_fixed();
        ph     = P_AFIXED;
        pos    = '0;
        rtype  = '0;
        rclass = '0;
        dlen   = '0;
    endfunction

    function void parse_byte(input logic [7:0] b);
        logic        take;
        logic [31:0] total;
        case (ph)
            P_HEADER: begin
                if (pos == 3)
                    rcode = b[3:0] & dra_pkg::RCODE_MASK[3:0];
                else if (pos == 6)
                    an_count = {b, 8'h00};
                else if (pos == 7)
                    an_count = an_count | {8'h00, b};
                pos = pos + 1'b1;
                if (pos >= dra_pkg::HEADER_LEN) begin
                    pos      = '0;
                    ans_left = an_count;
                    lbl_left = '0;
                    ph = (rcode != 0) ? P_DONE : P_QNAME;
                end
            end
            P_QNAME: begin
                if (name_step(b, P_QNAME_PTR)) begin
                    ph  = P_QTAIL;
                    pos = '0;
                end
            end
            P_QNAME_PTR: begin
                ph  = P_QTAIL;
                pos = '0;
            end
            P_QTAIL: begin
                pos = pos + 1'b1;
                if (pos >= dra_pkg::QTAIL_LEN) begin
                    pos = '0;
                    next_answer();
                end
            end
            P_ANAME: begin
                if (name_step(b, P_ANAME_PTR))
                    open_fixed();
            end
            P_ANAME_PTR: begin
                open_fixed();
            end
            P_AFIXED: begin
                if (pos < 2)
                    rtype = {rtype[7:0], b};
                else if (pos < 4)
                    rclass = {rclass[7:0], b};
                else if (pos >= 8)
                    dlen = {dlen[7:0], b};
                pos = pos + 1'b1;
                if (pos >= dra_pkg::FIXED_LEN) begin
                    pos = '0;
                    if (dlen == 0)
                        finish_record();
                    else
                        ph = P_ADATA;
                end
            end
            P_ADATA: begin
                // Only a record whose full data length is four bytes is taken.
                total = 32'(dlen) + 32'(pos);
                take = (rtype == 16'd1) && (rclass == 16'd1) && !addr_hit &&
                       (total == dra_pkg::ADDR_LEN);
                if (take)
                    addr_acc = {addr_acc[23:0], b};
                dlen = dlen - 1'b1;
                pos  = pos + 1'b1;
                if (dlen == 0) begin
                    if (take)
                        addr_hit = 1'b1;
                    pos = '0;
                    finish_record();
                end
            end
            default: begin
                ph = P_DONE;
            end
        endcase
    endfunction

    function automatic logic absorb_byte(input logic [7:0] b, input logic l,
                                         output t_reply r);
        r = '0;
        parse_byte(b);
        if (!l)
            return 1'b0;
        if (ph == P_HEADER)
            r.status = ST_TRUNCATED;
        else if (rcode != 0)
            r.status = ST_SERVER_ERR;
        else if (addr_hit)
            r.status = ST_RESOLVED;
        else if (ph != P_DONE)
            r.status = ST_TRUNCATED;
        else
            r.status = ST_NO_ANSWER;
        r.address = (r.status == ST_RESOLVED) ? addr_acc : 32'h0;
        r.rcode   = rcode;
        r.ancount = an_count;
        clear_parser();
        return 1'b1;
    endfunction

    task send_item(input logic [7:0] b, input logic l, input logic typed,
                   input t_reply want);
        t_reply got;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_payload_byte <= b;
        i_last_byte    <= l;
        do
            @(posedge i_clk);
        while (!o_ready);
        if (absorb_byte(b, l, got))
            expected_replies.push_back(typed ? want : got);
        sent_items++;
    endtask

    task send_dgram();
        for (int k = 0; k < dgram.size(); k++)
            send_item(dgram[k], k == dgram.size() - 1, 1'b0, '0);
    endtask

    task push_random(input int count);
        for (int k = 0; k < count; k++)
            dgram.push_back(8'($urandom));
    endtask

    // A name is the root label, a lone pointer, or labels ending in a zero
    // byte or in a pointer.
    task push_name();
        int kind;
        int nlabels;
        int len;
        kind = $urandom_range(0, 3);
        if (kind >= 2) begin
            nlabels = $urandom_range(1, 3);
            for (int k = 0; k < nlabels; k++) begin
                len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 8);
                dgram.push_back(8'(len));
                push_random(len);
            end
        end
        if (kind == 0 || kind == 2) begin
            dgram.push_back(8'h00);
        end else begin
            dgram.push_back(8'($urandom_range(8'h40, 8'hff)));
            push_random(1);
        end
    endtask

    task build_noise(input int min_len, input int max_len);
        dgram.delete();
        push_random($urandom_range(min_len, max_len));
    endtask

    task build_reply();
        int          pick;
        int          nrec;
        logic [3:0]  rc;
        logic [15:0] anc;
        logic [15:0] rd;
        dgram.delete();
        rc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            nrec = 0;
            anc  = 16'h0000;
        end else if (pick < 85) begin
            nrec = $urandom_range(1, 3);
            anc  = 16'(nrec);
        end else begin
            // The count is random, so it may claim more records than follow.
            nrec = $urandom_range(1, 3);
            anc  = 16'($urandom);
        end
        push_random(3);
        dgram.push_back({4'($urandom), rc});
        push_random(2);
        dgram.push_back(anc[15:8]);
        dgram.push_back(anc[7:0]);
        push_random(4);
        push_name();
        push_random(dra_pkg::QTAIL_LEN);
        for (int k = 0; k < nrec; k++) begin
            push_name();
            if ($urandom_range(0, 99) < 70) begin
                dgram.push_back(8'h00);
                dgram.push_back(8'h01);
            end else begin
                push_random(2);
            end
            if ($urandom_range(0, 99) < 80) begin
                dgram.push_back(8'h00);
                dgram.push_back(8'h01);
            end else begin
                push_random(2);
            end
            push_random(4);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                rd = 16'd4;
            else if (pick < 97)
                rd = 16'($urandom_range(0, 8));
            else
                rd = 16'($urandom_range(256, 300));
            dgram.push_back(rd[15:8]);
            dgram.push_back(rd[7:0]);
            push_random(int'(rd));
        end
        push_random($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) begin
            pick = $urandom_range(1, dgram.size());
            while (dgram.size() > pick)
                void'(dgram.pop_back());
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: status %0d address %h",
                         $time, o_status, o_resolved_address);
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_resolved_address !== want.address) begin
                    errors++;
                    $display("%0t: address expected %h actual %h",
                             $time, want.address, o_resolved_address);
                end
                if (o_response_code !== want.rcode) begin
                    errors++;
                    $display("%0t: rcode expected %0d actual %0d",
                             $time, want.rcode, o_response_code);
                end
                if (o_answer_total !== want.ancount) begin
                    errors++;
                    $display("%0t: answer count expected %h actual %h",
                             $time, want.ancount, o_answer_total);
                end
            end
        end
    end

    initial begin
        int m;
        clear_parser();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_item(dir_rows[k].data, dir_rows[k].last, dir_rows[k].typed,
                      dir_rows[k].want);

        m = 0;
        while (sent_items < 1100 || m < 12) begin
            if (m == 2) begin
                // Short datagrams sent while the receiver holds off, so
                // that the block fills up and stalls its input.
                holds_asked++;
                repeat (4) begin
                    build_noise(1, 4);
                    send_dgram();
                end
            end
            if (m == 5 || m == 10) begin
                i_valid <= 1'b0;
                while (expected_replies.size() != 0)
                    @(posedge i_clk);
                repeat (4) @(posedge i_clk);
            end
            calm = (m >= 6 && m < 9);
            if ($urandom_range(0, 99) < 15)
                build_noise(1, 30);
            else
                build_reply();
            send_dgram();
            m++;
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
